// File: rtl/core/qmsp_pkg.sv
package qmsp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 2048;
    localparam int MAX_FACES    = 1024;
    localparam int COORD_W      = 32;
    localparam int LINK_W       = 11;
    localparam int VTX_AW       = $clog2(MAX_VERTICES);
    localparam int EDGE_AW      = $clog2(MAX_EDGES);
    localparam int FACE_AW      = $clog2(MAX_FACES);
    localparam int CNT_W        = 12;
    // 8P plus eight neighbour terms: sixteen 32-bit values
    localparam int ACC_W        = COORD_W + 6;

    typedef enum logic [2:0] {
        FUNC_LD_VPOS  = 3'd0,
        FUNC_LD_VEDGE = 3'd1,
        FUNC_LD_EEND  = 3'd2,
        FUNC_LD_FEDGE = 3'd3,
        FUNC_RUN      = 3'd4,
        FUNC_RD_FACE  = 3'd5,
        FUNC_RD_EDGE  = 3'd6,
        FUNC_RD_VTX   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        KIND_FACE = 2'd0,
        KIND_EDGE = 2'd1,
        KIND_VTX  = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_EDGE_COUNT   = 2'd1,
        CFG_FACE_COUNT   = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] pt_t;

    typedef struct packed {
        logic [10:0] vertex_count;
        logic [11:0] edge_count;
        logic [10:0] face_count;
    } cfg_t;

    typedef struct packed {
        func_t               func;
        logic [10:0]         index;
        logic signed [31:0]  coord_x;
        logic signed [31:0]  coord_y;
        logic signed [31:0]  coord_z;
        logic [10:0]         ref_0;
        logic [10:0]         ref_1;
        logic [10:0]         ref_2;
        logic signed [11:0]  ref_3;
    } in_word_t;

    typedef struct packed {
        kind_t               point_kind;
        logic [10:0]         point_index;
        logic signed [31:0]  point_x;
        logic signed [31:0]  point_y;
        logic signed [31:0]  point_z;
    } out_word_t;

endpackage

// File: rtl/core/qmsp_core.sv
module qmsp_core
    import qmsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_fire,
    input  in_word_t  in_word,
    output logic      core_idle,
    output logic      res_valid,
    output out_word_t res_word
);

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_DONE,
        F_CHK, F_LINK, F_E1, F_E3, F_VA, F_VB, F_VC, F_VD, F_ADD, F_WR,
        E_CHK, E_LINK, E_VA, E_VB, E_ADD, E_WR,
        V_CHK, V_LINK, V_BASE, V_FE, V_NB, V_ADD, V_WR
    } state_t;

    typedef struct packed {
        logic                   has_fourth;
        logic [3:0][LINK_W-1:0] face;
    } vfl_t;
    typedef logic [3:0][LINK_W-1:0] vel_t;
    typedef logic [1:0][LINK_W-1:0] pair_t;

    // memories
    pt_t   vpos_mem [MAX_VERTICES];
    vfl_t  vfl_mem  [MAX_VERTICES];
    vel_t  vel_mem  [MAX_VERTICES];
    pair_t eend_mem [MAX_EDGES];
    pair_t fel_mem  [MAX_FACES];
    pt_t   fpt_mem  [MAX_FACES];
    pt_t   ept_mem  [MAX_EDGES];
    pt_t   mvt_mem  [MAX_VERTICES];

    logic               vpos_we, vfl_we, vel_we, eend_we, fel_we, fpt_we, ept_we, mvt_we;
    logic [VTX_AW-1:0]  vpos_wa, mvt_wa, vpos_ra, vfl_ra, mvt_ra;
    logic [EDGE_AW-1:0] eend_wa, ept_wa, eend_ra, ept_ra;
    logic [FACE_AW-1:0] fel_wa, fpt_wa, fel_ra, fpt_ra;
    pt_t                vpos_wd, fpt_wd, ept_wd, mvt_wd;
    pt_t                vpos_q, fpt_q, ept_q, mvt_q;
    vfl_t               vfl_wd, vfl_q;
    vel_t               vel_wd, vel_q;
    pair_t              eend_wd, eend_q, fel_wd, fel_q;

    always_ff @(posedge aclk) begin
        if (vpos_we) vpos_mem[vpos_wa] <= vpos_wd;
        if (vfl_we)  vfl_mem[vpos_wa]  <= vfl_wd;
        if (vel_we)  vel_mem[vpos_wa]  <= vel_wd;
        if (eend_we) eend_mem[eend_wa] <= eend_wd;
        if (fel_we)  fel_mem[fel_wa]   <= fel_wd;
        if (fpt_we)  fpt_mem[fpt_wa]   <= fpt_wd;
        if (ept_we)  ept_mem[ept_wa]   <= ept_wd;
        if (mvt_we)  mvt_mem[mvt_wa]   <= mvt_wd;
        vpos_q <= vpos_mem[vpos_ra];
        vfl_q  <= vfl_mem[vfl_ra];
        vel_q  <= vel_mem[vfl_ra];
        eend_q <= eend_mem[eend_ra];
        fel_q  <= fel_mem[fel_ra];
        fpt_q  <= fpt_mem[fpt_ra];
        ept_q  <= ept_mem[ept_ra];
        mvt_q  <= mvt_mem[mvt_ra];
    end

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]               j_reg, j_next;
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [ACC_W-1:0]  acc_next [3];
    logic [LINK_W-1:0]        e3_reg, e3_next, va_reg, va_next, vb_reg, vb_next;
    logic [LINK_W-1:0]        vc_reg, vc_next, vd_reg, vd_next;
    vfl_t                     vfl_reg, vfl_next;
    vel_t                     vel_reg, vel_next;
    logic                     pos_add_reg, pos_add_next, fp_add_reg, fp_add_next;
    kind_t                    rd_kind_reg, rd_kind_next;
    logic [10:0]              rd_idx_reg, rd_idx_next;
    logic                     rd_ok_reg, rd_ok_next;

    logic                     pos_issue, acc_clr, acc_load;
    logic [LINK_W-1:0]        pos_addr, fl, nb;
    pt_t                      rd_pt;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        e3_next      = e3_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        vc_next      = vc_reg;
        vd_next      = vd_reg;
        vfl_next     = vfl_reg;
        vel_next     = vel_reg;
        rd_kind_next = rd_kind_reg;
        rd_idx_next  = rd_idx_reg;
        rd_ok_next   = rd_ok_reg;
        pos_issue    = 1'b0;
        pos_addr     = va_reg;
        acc_clr      = 1'b0;
        acc_load     = 1'b0;
        fl           = vfl_reg.face[j_reg];
        nb           = (eend_q[0] == cnt_reg[LINK_W-1:0]) ? eend_q[1] : eend_q[0];
        fp_add_next  = 1'b0;

        vpos_we = 1'b0; vfl_we = 1'b0; vel_we = 1'b0; eend_we = 1'b0;
        fel_we  = 1'b0; fpt_we = 1'b0; ept_we = 1'b0; mvt_we  = 1'b0;
        vpos_wa = in_word.index[VTX_AW-1:0];
        eend_wa = in_word.index[EDGE_AW-1:0];
        fel_wa  = in_word.index[FACE_AW-1:0];
        fpt_wa  = cnt_reg[FACE_AW-1:0];
        ept_wa  = cnt_reg[EDGE_AW-1:0];
        mvt_wa  = cnt_reg[VTX_AW-1:0];
        vpos_wd[0] = in_word.coord_x;
        vpos_wd[1] = in_word.coord_y;
        vpos_wd[2] = in_word.coord_z;
        vfl_wd.has_fourth = !in_word.ref_3[11];
        vfl_wd.face[0] = in_word.ref_0;
        vfl_wd.face[1] = in_word.ref_1;
        vfl_wd.face[2] = in_word.ref_2;
        vfl_wd.face[3] = in_word.ref_3[11] ? '0 : in_word.ref_3[LINK_W-1:0];
        vel_wd[0] = in_word.ref_0;
        vel_wd[1] = in_word.ref_1;
        vel_wd[2] = in_word.ref_2;
        vel_wd[3] = in_word.ref_3[LINK_W-1:0];
        eend_wd[0] = in_word.ref_0;
        eend_wd[1] = in_word.ref_1;
        fel_wd[0]  = in_word.ref_0;
        fel_wd[1]  = in_word.ref_1;
        for (int k = 0; k < 3; k++) begin
            fpt_wd[k] = acc_reg[k][COORD_W+1:2];
            ept_wd[k] = acc_reg[k][COORD_W:1];
            mvt_wd[k] = acc_reg[k][COORD_W+3:4];
        end

        vfl_ra  = cnt_reg[VTX_AW-1:0];
        fel_ra  = cnt_reg[FACE_AW-1:0];
        eend_ra = cnt_reg[EDGE_AW-1:0];
        fpt_ra  = fl[FACE_AW-1:0];
        ept_ra  = in_word.index[EDGE_AW-1:0];
        mvt_ra  = in_word.index[VTX_AW-1:0];

        res_valid = 1'b0;
        res_word  = '0;
        for (int k = 0; k < 3; k++) begin
            unique case (rd_kind_reg)
                KIND_FACE: rd_pt[k] = fpt_q[k];
                KIND_EDGE: rd_pt[k] = ept_q[k];
                default:   rd_pt[k] = mvt_q[k];
            endcase
            if (!rd_ok_reg) rd_pt[k] = '0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    rd_idx_next = in_word.index;
                    fpt_ra      = in_word.index[FACE_AW-1:0];
                    unique case (in_word.func)
                        FUNC_LD_VPOS: begin
                            vpos_we = !in_word.index[10];
                            vfl_we  = !in_word.index[10];
                        end
                        FUNC_LD_VEDGE: vel_we  = !in_word.index[10];
                        FUNC_LD_EEND:  eend_we = 1'b1;
                        FUNC_LD_FEDGE: fel_we  = !in_word.index[10];
                        FUNC_RUN: begin
                            cnt_next   = '0;
                            state_next = F_CHK;
                        end
                        FUNC_RD_FACE: begin
                            rd_kind_next = KIND_FACE;
                            rd_ok_next   = !in_word.index[10];
                            state_next   = S_RD;
                        end
                        FUNC_RD_EDGE: begin
                            rd_kind_next = KIND_EDGE;
                            rd_ok_next   = 1'b1;
                            state_next   = S_RD;
                        end
                        FUNC_RD_VTX: begin
                            rd_kind_next = KIND_VTX;
                            rd_ok_next   = !in_word.index[10];
                            state_next   = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                res_valid            = 1'b1;
                res_word.point_kind  = rd_kind_reg;
                res_word.point_index = rd_idx_reg;
                res_word.point_x     = rd_pt[0];
                res_word.point_y     = rd_pt[1];
                res_word.point_z     = rd_pt[2];
                state_next           = S_IDLE;
            end
            S_DONE: begin
                res_valid           = 1'b1;
                res_word.point_kind = KIND_DONE;
                state_next          = S_IDLE;
            end
            // face pass
            F_CHK: begin
                if (cnt_reg == {1'b0, cfg.face_count}) begin
                    cnt_next   = '0;
                    state_next = E_CHK;
                end else begin
                    state_next = F_LINK;
                end
            end
            F_LINK: state_next = F_E1;
            F_E1: begin
                e3_next    = fel_q[1];
                eend_ra    = fel_q[0];
                acc_clr    = 1'b1;
                state_next = F_E3;
            end
            F_E3: begin
                va_next    = eend_q[0];
                vb_next    = eend_q[1];
                eend_ra    = e3_reg;
                state_next = F_VA;
            end
            F_VA: begin
                vc_next    = eend_q[0];
                vd_next    = eend_q[1];
                pos_issue  = 1'b1;
                pos_addr   = va_reg;
                state_next = F_VB;
            end
            F_VB: begin
                pos_issue  = 1'b1;
                pos_addr   = vb_reg;
                state_next = F_VC;
            end
            F_VC: begin
                pos_issue  = 1'b1;
                pos_addr   = vc_reg;
                state_next = F_VD;
            end
            F_VD: begin
                pos_issue  = 1'b1;
                pos_addr   = vd_reg;
                state_next = F_ADD;
            end
            F_ADD: state_next = F_WR;
            F_WR: begin
                fpt_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = F_CHK;
            end
            // edge pass
            E_CHK: begin
                if (cnt_reg == cfg.edge_count) begin
                    cnt_next   = '0;
                    state_next = V_CHK;
                end else begin
                    state_next = E_LINK;
                end
            end
            E_LINK: begin
                acc_clr    = 1'b1;
                state_next = E_VA;
            end
            E_VA: begin
                vb_next    = eend_q[1];
                pos_issue  = 1'b1;
                pos_addr   = eend_q[0];
                state_next = E_VB;
            end
            E_VB: begin
                pos_issue  = 1'b1;
                pos_addr   = vb_reg;
                state_next = E_ADD;
            end
            E_ADD: state_next = E_WR;
            E_WR: begin
                ept_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = E_CHK;
            end
            // vertex pass
            V_CHK: begin
                if (cnt_reg == {1'b0, cfg.vertex_count}) begin
                    state_next = S_DONE;
                end else begin
                    state_next = V_LINK;
                end
            end
            V_LINK: begin
                pos_addr   = cnt_reg[LINK_W-1:0];
                state_next = V_BASE;
            end
            V_BASE: begin
                vfl_next = vfl_q;
                vel_next = vel_q;
                acc_load = 1'b1;
                j_next   = '0;
                if (!vfl_q.has_fourth) begin
                    mvt_we     = 1'b1;
                    mvt_wd     = vpos_q;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = V_CHK;
                end else begin
                    state_next = V_FE;
                end
            end
            V_FE: begin
                fp_add_next = !fl[LINK_W-1];
                eend_ra     = vel_reg[j_reg];
                state_next  = V_NB;
            end
            V_NB: begin
                pos_issue = 1'b1;
                pos_addr  = nb;
                j_next    = j_reg + 1'b1;
                if (j_reg == 2'd3) begin
                    state_next = V_ADD;
                end else begin
                    state_next = V_FE;
                end
            end
            V_ADD: state_next = V_WR;
            V_WR: begin
                mvt_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = V_CHK;
            end
            default: state_next = S_IDLE;
        endcase

        vpos_ra      = pos_addr[VTX_AW-1:0];
        // links at or above the vertex depth read as the origin
        pos_add_next = pos_issue && !pos_addr[LINK_W-1];

        for (int k = 0; k < 3; k++) begin
            priority if (acc_clr) begin
                acc_next[k] = '0;
            end else if (acc_load) begin
                acc_next[k] = {{(ACC_W-COORD_W-3){vpos_q[k][COORD_W-1]}}, vpos_q[k], 3'b000};
            end else begin
                acc_next[k] = acc_reg[k]
                    + (pos_add_reg ? ACC_W'(vpos_q[k]) : ACC_W'(0))
                    + (fp_add_reg  ? ACC_W'(fpt_q[k])  : ACC_W'(0));
            end
        end
    end

    assign core_idle = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            j_reg       <= '0;
            pos_add_reg <= 1'b0;
            fp_add_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            j_reg       <= j_next;
            pos_add_reg <= pos_add_next;
            fp_add_reg  <= fp_add_next;
        end
        e3_reg      <= e3_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        vc_reg      <= vc_next;
        vd_reg      <= vd_next;
        vfl_reg     <= vfl_next;
        vel_reg     <= vel_next;
        rd_kind_reg <= rd_kind_next;
        rd_idx_reg  <= rd_idx_next;
        rd_ok_reg   <= rd_ok_next;
        for (int k = 0; k < 3; k++) acc_reg[k] <= acc_next[k];
    end

endmodule

// File: rtl/core/quad_mesh_subdivision_points_unit.sv
// Quad mesh subdivision point unit. Words with func 0-3 load vertex
// positions and links, edge endpoints and face edges; while the core is idle
// they are taken one per cycle and give no result. A read (func 5-7) goes
// through the synchronous store read and then to the output register.
// A run walks the faces, edges and vertices through one vertex position
// memory port and ends with one run-done word. Coordinates are Q16.16,
// every point is rounded toward minus infinity.
module quad_mesh_subdivision_points_unit
    import qmsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  cfg_idx_t    cfg_addr,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word
);

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_word_t m_word_reg;
    logic      core_idle, res_valid, out_free, in_fire;
    out_word_t res_word;

    assign out_free = !m_valid_reg || m_ready;
    // loads never produce a word, so they pass while the output waits
    assign s_ready  = core_idle && (out_free || !s_word.func[2]);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    qmsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .in_word   (s_word),
        .core_idle (core_idle),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_VERTEX_COUNT: cfg_reg.vertex_count <=
                        (cfg_wr_data[10:0] > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES)
                                                                : cfg_wr_data[10:0];
                    CFG_EDGE_COUNT: cfg_reg.edge_count <=
                        (cfg_wr_data > 12'(MAX_EDGES)) ? 12'(MAX_EDGES) : cfg_wr_data;
                    CFG_FACE_COUNT: cfg_reg.face_count <=
                        (cfg_wr_data[10:0] > 11'(MAX_FACES)) ? 11'(MAX_FACES)
                                                             : cfg_wr_data[10:0];
                    default: ;
                endcase
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) m_word_reg <= res_word;
    end

`ifndef SYNTHESIS
    a_res_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result word with output register occupied");
    a_read_next: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_word.func[2] && (s_word.func[1] || s_word.func[0]) |=> res_valid)
        else $error("read word did not appear one cycle after accept");
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_word.func == FUNC_RUN) |=> !core_idle && !res_valid)
        else $error("run did not start");
`endif

endmodule
